@@ sv/lhp_pkg.sv @@
// shared constants and types of the local-history branch predictor
package lhp_pkg;

    localparam int HISTORY_ENTRIES_DEF = 512;
    localparam int HISTORY_BITS_DEF    = 6;
    localparam int PATTERN_SETS_DEF    = 8;

    localparam int PC_W = 32;
    localparam int CTR_W = 2;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    localparam logic [CTR_W-1:0] CTR_MAX       = 2'd3;
    localparam logic [CTR_W-1:0] CTR_MIN       = 2'd0;
    localparam logic [CTR_W-1:0] CTR_THRESHOLD = 2'd2;
    localparam logic [CTR_W-1:0] CTR_RESET     = 2'd1;

    // widest addresses and data over the parameter ranges
    localparam int HIST_ADDR_MAX_W = 16;
    localparam int HIST_DATA_MAX_W = 16;
    localparam int CTR_ADDR_MAX_W  = 22;

    typedef struct packed {
        logic                       hist_rd_en;
        logic [HIST_ADDR_MAX_W-1:0] hist_rd_addr;
        logic                       hist_wr_en;
        logic [HIST_ADDR_MAX_W-1:0] hist_wr_addr;
        logic [HIST_DATA_MAX_W-1:0] hist_wr_data;
        logic                       ctr_rd_en;
        logic [CTR_ADDR_MAX_W-1:0]  ctr_rd_addr;
        logic                       ctr_wr_en;
        logic [CTR_ADDR_MAX_W-1:0]  ctr_wr_addr;
        logic [CTR_W-1:0]           ctr_wr_data;
    } t_tbl_req;

endpackage

@@ sv/lhp_req_if.sv @@
// request channel: lookup or update word
interface lhp_req_if;
    import lhp_pkg::*;

    logic            valid;
    logic            ready;
    logic            op;
    logic [PC_W-1:0] pc;
    logic            taken;

    modport source (output valid, output op, output pc, output taken, input ready);
    modport sink   (input valid, input op, input pc, input taken, output ready);
endinterface

@@ sv/lhp_rsp_if.sv @@
// response channel: prediction word
interface lhp_rsp_if;
    logic valid;
    logic ready;
    logic predict_taken;

    modport source (output valid, output predict_taken, input ready);
    modport sink   (input valid, input predict_taken, output ready);
endinterface

@@ sv/lhp_index.sv @@
// set and history slot from the branch address, shift or reciprocal multiply
module lhp_index #(
    parameter int PATTERN_SETS    = lhp_pkg::PATTERN_SETS_DEF,
    parameter int HISTORY_ENTRIES = lhp_pkg::HISTORY_ENTRIES_DEF,
    parameter int SET_W  = (PATTERN_SETS > 1) ? $clog2(PATTERN_SETS) : 1,
    parameter int SLOT_W = $clog2(HISTORY_ENTRIES)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lhp_pkg::PC_W-1:0]  i_pc,
    output logic                      o_done,
    output logic [SET_W-1:0]          o_set,
    output logic [SLOT_W-1:0]         o_slot
);
    import lhp_pkg::*;

    localparam bit SETS_POW2    = (PATTERN_SETS & (PATTERN_SETS - 1)) == 0;
    localparam bit ENTRIES_POW2 = (HISTORY_ENTRIES & (HISTORY_ENTRIES - 1)) == 0;

    generate
        if (SETS_POW2 && ENTRIES_POW2) begin : g_shift
            localparam int SET_SHIFT = $clog2(PATTERN_SETS);
            localparam logic [PC_W-1:0] SET_MASK = PC_W'(PATTERN_SETS - 1);

            logic              r_done;
            logic [SET_W-1:0]  r_set;
            logic [SLOT_W-1:0] r_slot;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_set  <= SET_W'(i_pc & SET_MASK);
                    r_slot <= SLOT_W'(i_pc >> SET_SHIFT);
                end
            end

            assign o_done = r_done;
            assign o_set  = r_set;
            assign o_slot = r_slot;
        end else begin : g_recip
            localparam int HALF   = 17;
            localparam int PROD_W = PC_W + HALF;
            localparam int ACC_W  = 2 * PC_W + 1;
            localparam int SK     = PC_W + $clog2(PATTERN_SETS);
            localparam int EK     = PC_W + $clog2(HISTORY_ENTRIES);
            localparam longint unsigned SM =
                ((64'd1 << SK) + 64'(PATTERN_SETS) - 64'd1) / 64'(PATTERN_SETS);
            localparam longint unsigned EM =
                ((64'd1 << EK) + 64'(HISTORY_ENTRIES) - 64'd1) / 64'(HISTORY_ENTRIES);
            localparam logic [HALF-1:0]   SM_LO = HALF'(SM);
            localparam logic [HALF-1:0]   SM_HI = HALF'(SM >> HALF);
            localparam logic [HALF-1:0]   EM_LO = HALF'(EM);
            localparam logic [HALF-1:0]   EM_HI = HALF'(EM >> HALF);
            localparam logic [SET_W-1:0]  S_LOW = SET_W'(PATTERN_SETS);
            localparam logic [SLOT_W-1:0] E_LOW = SLOT_W'(HISTORY_ENTRIES);

            localparam logic [2:0] ST_S_LO = 3'd0;
            localparam logic [2:0] ST_S_HI = 3'd1;
            localparam logic [2:0] ST_E_LO = 3'd2;
            localparam logic [2:0] ST_E_HI = 3'd3;
            localparam logic [2:0] ST_FOLD = 3'd4;

            logic              r_busy;
            logic              r_done;
            logic [2:0]        r_step;
            logic [PC_W-1:0]   r_pc;
            logic [PC_W-1:0]   r_q1;
            logic [PC_W-1:0]   r_q2;
            logic [ACC_W-1:0]  r_acc;
            logic [SET_W-1:0]  r_set;
            logic [SLOT_W-1:0] r_slot;
            logic [PC_W-1:0]   mul_a;
            logic [HALF-1:0]   mul_b;
            logic [PROD_W-1:0] prod;
            logic [ACC_W-1:0]  acc_sum;
            logic [SET_W-1:0]  set_prod;
            logic [SLOT_W-1:0] slot_prod;

            // quotient by the set count, then by the entries, 17-bit slices of the reciprocal
            always_comb begin
                mul_a = (r_step < ST_E_LO) ? r_pc : r_q1;
                case (r_step)
                    ST_S_LO: mul_b = SM_LO;
                    ST_S_HI: mul_b = SM_HI;
                    ST_E_LO: mul_b = EM_LO;
                    default: mul_b = EM_HI;
                endcase
                prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
                acc_sum   = r_acc + (ACC_W'(prod) << HALF);
                set_prod  = r_q1[SET_W-1:0] * S_LOW;
                slot_prod = r_q2[SLOT_W-1:0] * E_LOW;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_step <= ST_S_LO;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_step <= ST_S_LO;
                    end else if (r_busy) begin
                        if (r_step == ST_FOLD) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_step <= r_step + 3'd1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_pc <= i_pc;
                end else if (r_busy) begin
                    case (r_step)
                        ST_S_LO: r_acc <= ACC_W'(prod);
                        ST_S_HI: r_q1  <= PC_W'(acc_sum >> SK);
                        ST_E_LO: r_acc <= ACC_W'(prod);
                        ST_E_HI: r_q2  <= PC_W'(acc_sum >> EK);
                        default: begin
                            r_set  <= r_pc[SET_W-1:0] - set_prod;
                            r_slot <= r_q1[SLOT_W-1:0] - slot_prod;
                        end
                    endcase
                end
            end

            assign o_done = r_done;
            assign o_set  = r_set;
            assign o_slot = r_slot;
        end
    endgenerate

endmodule

@@ sv/lhp_tables.sv @@
// history table and pattern counter memories, registered read data
module lhp_tables #(
    parameter int HISTORY_ENTRIES = lhp_pkg::HISTORY_ENTRIES_DEF,
    parameter int HISTORY_BITS    = lhp_pkg::HISTORY_BITS_DEF,
    parameter int PATTERN_SETS    = lhp_pkg::PATTERN_SETS_DEF
) (
    input  logic                        i_clk,
    input  lhp_pkg::t_tbl_req           i_req,
    output logic [HISTORY_BITS-1:0]     o_hist_rdata,
    output logic [lhp_pkg::CTR_W-1:0]   o_ctr_rdata
);
    import lhp_pkg::*;

    localparam int CTR_TOTAL = PATTERN_SETS * (1 << HISTORY_BITS);
    localparam int HADDR_W   = $clog2(HISTORY_ENTRIES);
    localparam int CADDR_W   = $clog2(CTR_TOTAL);

    logic [HISTORY_BITS-1:0] r_hist_mem [HISTORY_ENTRIES];
    logic [CTR_W-1:0]        r_ctr_mem  [CTR_TOTAL];
    logic [HISTORY_BITS-1:0] r_hist_rdata;
    logic [CTR_W-1:0]        r_ctr_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.hist_wr_en) begin
            r_hist_mem[i_req.hist_wr_addr[HADDR_W-1:0]] <=
                i_req.hist_wr_data[HISTORY_BITS-1:0];
        end
        if (i_req.hist_rd_en) begin
            r_hist_rdata <= r_hist_mem[i_req.hist_rd_addr[HADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ctr_wr_en) begin
            r_ctr_mem[i_req.ctr_wr_addr[CADDR_W-1:0]] <= i_req.ctr_wr_data;
        end
        if (i_req.ctr_rd_en) begin
            r_ctr_rdata <= r_ctr_mem[i_req.ctr_rd_addr[CADDR_W-1:0]];
        end
    end

    assign o_hist_rdata = r_hist_rdata;
    assign o_ctr_rdata  = r_ctr_rdata;

endmodule

@@ sv/local_history_two_level_predictor_unit.sv @@
// top level of the two-level local-history branch predictor
//
//   channel   dir   word                  handshake
//   i_req     in    op, pc, taken         valid / ready
//   o_rsp     out   predict_taken         valid / ready
//
// one word at a time; lhp_index uses a reciprocal multiply unless the set and entry
// counts are powers of two (five steps: four reciprocal slices, then a fold).
// each word reads the history table, then the pattern counters, then on an update writes both.
// after reset a clearing pass over max(HISTORY_ENTRIES, PATTERN_SETS*2^HISTORY_BITS)
// table slots (512 at the defaults) runs with i_req.ready low.
// a result waits in the output register; the next word is taken meanwhile and
// holds at its write-back until the output register is free.
module local_history_two_level_predictor_unit #(
    parameter int HISTORY_ENTRIES = lhp_pkg::HISTORY_ENTRIES_DEF,
    parameter int HISTORY_BITS    = lhp_pkg::HISTORY_BITS_DEF,
    parameter int PATTERN_SETS    = lhp_pkg::PATTERN_SETS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lhp_req_if.sink     i_req,
    lhp_rsp_if.source   o_rsp
);
    import lhp_pkg::*;

    localparam int SET_W     = (PATTERN_SETS > 1) ? $clog2(PATTERN_SETS) : 1;
    localparam int SLOT_W    = $clog2(HISTORY_ENTRIES);
    localparam int CTR_TOTAL = PATTERN_SETS * (1 << HISTORY_BITS);
    localparam int CIDX_W    = $clog2(CTR_TOTAL);
    localparam int CLR_TOTAL = (CTR_TOTAL > HISTORY_ENTRIES) ? CTR_TOTAL : HISTORY_ENTRIES;
    localparam int CLR_W     = $clog2(CLR_TOTAL + 1);
    localparam logic [CLR_W-1:0] CLR_LAST     = CLR_W'(CLR_TOTAL - 1);
    localparam logic [CLR_W-1:0] CLR_HIST_END = CLR_W'(HISTORY_ENTRIES);
    localparam logic [CLR_W-1:0] CLR_CTR_END  = CLR_W'(CTR_TOTAL);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_INDEX = 3'd2;
    localparam logic [2:0] S_HIST  = 3'd3;
    localparam logic [2:0] S_CTR   = 3'd4;

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    logic [CLR_W-1:0]           r_clr_idx;
    logic                       r_op;
    logic                       r_taken;
    logic                       r_out_valid;
    logic                       r_out_taken;

    logic                       in_acc;
    logic                       out_free;
    logic                       idx_done;
    logic [SET_W-1:0]           idx_set;
    logic [SLOT_W-1:0]          idx_slot;
    logic [HISTORY_BITS-1:0]    hist_cur;
    logic [CTR_W-1:0]           ctr_cur;
    logic [SET_W+HISTORY_BITS-1:0] cidx_full;
    logic [CIDX_W-1:0]          cidx;
    logic [HISTORY_BITS:0]      hist_shift;
    logic [CTR_W-1:0]           ctr_next;
    logic                       pred;
    t_tbl_req                   tbl_req;

    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    lhp_index #(
        .PATTERN_SETS    (PATTERN_SETS),
        .HISTORY_ENTRIES (HISTORY_ENTRIES),
        .SET_W           (SET_W),
        .SLOT_W          (SLOT_W)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_pc    (i_req.pc),
        .o_done  (idx_done),
        .o_set   (idx_set),
        .o_slot  (idx_slot)
    );

    lhp_tables #(
        .HISTORY_ENTRIES (HISTORY_ENTRIES),
        .HISTORY_BITS    (HISTORY_BITS),
        .PATTERN_SETS    (PATTERN_SETS)
    ) u_tables (
        .i_clk        (i_clk),
        .i_req        (tbl_req),
        .o_hist_rdata (hist_cur),
        .o_ctr_rdata  (ctr_cur)
    );

    always_comb begin
        cidx_full  = {idx_set, hist_cur};
        cidx       = cidx_full[CIDX_W-1:0];
        hist_shift = {hist_cur, r_taken};
        pred       = ctr_cur >= CTR_THRESHOLD;
        ctr_next   = ctr_cur;
        if (r_taken && ctr_cur != CTR_MAX) begin
            ctr_next = ctr_cur + 1'b1;
        end else if (!r_taken && ctr_cur != CTR_MIN) begin
            ctr_next = ctr_cur - 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        tbl_req = '0;
        unique case (r_state)
            S_CLEAR: begin
                tbl_req.hist_wr_en   = r_clr_idx < CLR_HIST_END;
                tbl_req.hist_wr_addr = HIST_ADDR_MAX_W'(r_clr_idx);
                tbl_req.hist_wr_data = '0;
                tbl_req.ctr_wr_en    = r_clr_idx < CLR_CTR_END;
                tbl_req.ctr_wr_addr  = CTR_ADDR_MAX_W'(r_clr_idx);
                tbl_req.ctr_wr_data  = CTR_RESET;
                if (r_clr_idx == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_INDEX;
                end
            end
            S_INDEX: begin
                if (idx_done) begin
                    tbl_req.hist_rd_en   = 1'b1;
                    tbl_req.hist_rd_addr = HIST_ADDR_MAX_W'(idx_slot);
                    n_state = S_HIST;
                end
            end
            S_HIST: begin
                tbl_req.ctr_rd_en   = 1'b1;
                tbl_req.ctr_rd_addr = CTR_ADDR_MAX_W'(cidx);
                n_state = S_CTR;
            end
            S_CTR: begin
                if (out_free) begin
                    tbl_req.ctr_wr_en    = (r_op == OP_UPDATE);
                    tbl_req.ctr_wr_addr  = CTR_ADDR_MAX_W'(cidx);
                    tbl_req.ctr_wr_data  = ctr_next;
                    tbl_req.hist_wr_en   = (r_op == OP_UPDATE);
                    tbl_req.hist_wr_addr = HIST_ADDR_MAX_W'(idx_slot);
                    tbl_req.hist_wr_data = HIST_DATA_MAX_W'(hist_shift[HISTORY_BITS-1:0]);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (r_state == S_CTR && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_req.op;
            r_taken <= i_req.taken;
        end
        if (r_state == S_CTR && out_free) begin
            r_out_taken <= pred;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.predict_taken = r_out_taken;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_req.ready)
        else $error("word accepted during clearing pass");

    a_accept_starts_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_INDEX))
        else $error("accepted word did not start index");

    a_result_from_ctr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> ($past(r_state) == S_CTR))
        else $error("result raised outside counter stage");

    a_ctr_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_req.ctr_wr_en |->
            (r_state == S_CLEAR || (r_state == S_CTR && r_op == OP_UPDATE)))
        else $error("counter write outside clear or update");

    a_hist_write_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CTR && tbl_req.hist_wr_en) |-> tbl_req.ctr_wr_en)
        else $error("history written without counter update");

endmodule
